### hw/rtl/itoar_pkg.sv
`default_nettype none

package itoar_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 11;
    localparam int DEC_DIGITS = 10;
    localparam int OCT_W      = 3;
    localparam int DIGITS_W   = NUM_DIGITS * DIGIT_W;
    localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
    localparam int SHIFT_CNT_W = $clog2(VALUE_W);

    localparam logic [1:0] OP_DEC    = 2'd0;
    localparam logic [1:0] OP_OCT    = 2'd1;
    localparam logic [1:0] OP_HEX_UP = 2'd2;
    localparam logic [1:0] OP_HEX_LO = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    // Load request from the control sequencer to the digit emitter.
    typedef struct packed {
        logic load;
        logic lower;
    } emit_cmd_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            digit_char = CHAR_ZERO + ext;
        end
        else if (lower) begin
            digit_char = CHAR_LOWER_A + ext - 8'd10;
        end
        else begin
            digit_char = CHAR_UPPER_A + ext - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/itoar_dabble.sv
`default_nettype none

// Bit-serial binary to BCD conversion: one input bit enters per cycle,
// each BCD digit is adjusted by add-3 before every shift.
module itoar_dabble
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [itoar_pkg::VALUE_W-1:0]   value,
    output logic                                 done,
    output logic      [itoar_pkg::BCD_W-1:0]     bcd
);

    logic [itoar_pkg::VALUE_W-1:0]     bin_reg;
    logic [itoar_pkg::BCD_W-1:0]       bcd_reg;
    logic [itoar_pkg::BCD_W-1:0]       adj;
    logic [itoar_pkg::SHIFT_CNT_W-1:0] cnt_reg;
    logic                              run_reg;
    logic                              done_reg;

    always_comb
    begin
        for (int i = 0; i < itoar_pkg::DEC_DIGITS; i++)
        begin
            if (bcd_reg[i*itoar_pkg::DIGIT_W +: itoar_pkg::DIGIT_W] >= 4'd5) begin
                adj[i*itoar_pkg::DIGIT_W +: itoar_pkg::DIGIT_W] =
                    bcd_reg[i*itoar_pkg::DIGIT_W +: itoar_pkg::DIGIT_W] + 4'd3;
            end
            else begin
                adj[i*itoar_pkg::DIGIT_W +: itoar_pkg::DIGIT_W] =
                    bcd_reg[i*itoar_pkg::DIGIT_W +: itoar_pkg::DIGIT_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == itoar_pkg::SHIFT_CNT_W'(itoar_pkg::VALUE_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (run_reg) begin
            bin_reg <= {bin_reg[itoar_pkg::VALUE_W-2:0], 1'b0};
            bcd_reg <= {adj[itoar_pkg::BCD_W-2:0], bin_reg[itoar_pkg::VALUE_W-1]};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

### hw/rtl/itoar_emit.sv
`default_nettype none

// Digit shift register: drops leading zero digits, then sends one
// character per cycle from the most significant digit down.
module itoar_emit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire itoar_pkg::emit_cmd_t              cmd,
    input  wire logic [itoar_pkg::DIGITS_W-1:0]    digits,
    output logic                                   busy,
    output logic                                   strobe,
    output logic      [itoar_pkg::CHAR_W-1:0]      character,
    output logic                                   last,
    output logic      [itoar_pkg::COUNT_W-1:0]     char_count
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_SKIP,
        E_EMIT
    } emit_state_t;

    emit_state_t                          state_reg, state_next;
    logic [itoar_pkg::DIGITS_W-1:0]       dig_reg, dig_next;
    logic [itoar_pkg::COUNT_W-1:0]        rem_reg, rem_next;
    logic [itoar_pkg::COUNT_W-1:0]        cnt_reg, cnt_next;
    logic                                 lower_reg, lower_next;
    logic [itoar_pkg::DIGIT_W-1:0]        top_digit;
    logic [itoar_pkg::DIGITS_W-1:0]       dig_shifted;

    assign top_digit   = dig_reg[itoar_pkg::DIGITS_W-1 -: itoar_pkg::DIGIT_W];
    assign dig_shifted = {dig_reg[itoar_pkg::DIGITS_W-itoar_pkg::DIGIT_W-1:0],
                          {itoar_pkg::DIGIT_W{1'b0}}};

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        lower_next = lower_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (cmd.load) begin
                    dig_next   = digits;
                    rem_next   = itoar_pkg::COUNT_W'(itoar_pkg::NUM_DIGITS);
                    lower_next = cmd.lower;
                    state_next = E_SKIP;
                end
            end
            E_SKIP:
            begin
                // The last digit is always sent, so a zero value gives '0'.
                if (top_digit == '0 && rem_reg != 4'd1) begin
                    dig_next = dig_shifted;
                    rem_next = rem_reg - 1'b1;
                end
                else begin
                    cnt_next   = '0;
                    state_next = E_EMIT;
                end
            end
            E_EMIT:
            begin
                dig_next = dig_shifted;
                rem_next = rem_reg - 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (rem_reg == 4'd1) begin
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= E_IDLE;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        lower_reg <= lower_next;
    end

    assign busy       = (state_reg != E_IDLE);
    assign strobe     = (state_reg == E_EMIT);
    assign character  = itoar_pkg::digit_char(top_digit, lower_reg);
    assign last       = strobe && (rem_reg == 4'd1);
    assign char_count = last ? (cnt_reg + 1'b1) : '0;

endmodule

`default_nettype wire

### hw/rtl/integer_to_ascii_radix.sv
`default_nettype none

// Converts a 32-bit unsigned value to ASCII digits in decimal, octal or
// hex (upper or lower case), most significant digit first, without leading
// zeros. A transfer is taken when start is high while busy is low; busy
// then stays high until the emitter is idle after the last character.
// Characters leave on strobe, one per cycle, each present for exactly one
// cycle; the receiver cannot stall the stream, so it must take every
// strobed character. The last character carries last and the total count.
// Octal and hex go from the accept cycle through dropping the leading zero
// digits, seeing the first nonzero digit and sending the characters, and
// busy drops after the last character. Decimal first runs the bit-serial
// binary-to-BCD converter, which shifts in one value bit per cycle.
module integer_to_ascii_radix
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          op,
    input  wire logic [itoar_pkg::VALUE_W-1:0]       value,
    output logic                                     strobe,
    output logic      [itoar_pkg::CHAR_W-1:0]        character,
    output logic                                     last,
    output logic      [itoar_pkg::COUNT_W-1:0]       char_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DABBLE,
        S_DRAIN
    } ctrl_state_t;

    ctrl_state_t                       state_reg, state_next;
    logic                              dab_start;
    logic                              dab_done;
    logic [itoar_pkg::BCD_W-1:0]       bcd;
    logic [itoar_pkg::DIGITS_W-1:0]    oct_digits;
    logic [itoar_pkg::DIGITS_W-1:0]    load_digits;
    itoar_pkg::emit_cmd_t              cmd;
    logic                              emit_busy;
    logic                              accept;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        for (int i = 0; i < itoar_pkg::NUM_DIGITS - 1; i++)
        begin
            oct_digits[i*itoar_pkg::DIGIT_W +: itoar_pkg::DIGIT_W] =
                {1'b0, value[i*itoar_pkg::OCT_W +: itoar_pkg::OCT_W]};
        end
        oct_digits[itoar_pkg::DIGITS_W-1 -: itoar_pkg::DIGIT_W] =
            {2'b00, value[itoar_pkg::VALUE_W-1 -: 2]};
    end

    always_comb
    begin
        state_next  = state_reg;
        dab_start   = 1'b0;
        cmd.load    = 1'b0;
        cmd.lower   = 1'b0;
        load_digits = {{(itoar_pkg::DIGITS_W-itoar_pkg::BCD_W){1'b0}}, bcd};
        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    case (op)
                        itoar_pkg::OP_DEC:
                        begin
                            dab_start  = 1'b1;
                            state_next = S_DABBLE;
                        end
                        itoar_pkg::OP_OCT:
                        begin
                            cmd.load    = 1'b1;
                            load_digits = oct_digits;
                            state_next  = S_DRAIN;
                        end
                        default:
                        begin
                            cmd.load    = 1'b1;
                            cmd.lower   = (op == itoar_pkg::OP_HEX_LO);
                            load_digits = {{(itoar_pkg::DIGITS_W-itoar_pkg::VALUE_W){1'b0}},
                                           value};
                            state_next  = S_DRAIN;
                        end
                    endcase
                end
            end
            S_DABBLE:
            begin
                if (dab_done) begin
                    cmd.load   = 1'b1;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!emit_busy) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    itoar_dabble u_dabble
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .value (value),
        .done  (dab_done),
        .bcd   (bcd)
    );

    itoar_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .digits     (load_digits),
        .busy       (emit_busy),
        .strobe     (strobe),
        .character  (character),
        .last       (last),
        .char_count (char_count)
    );

endmodule

`default_nettype wire

### verif/itoar_checker.sv
`timescale 1ns / 1ps

module itoar_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic [1:0]                     op,
    input  wire logic [itoar_pkg::VALUE_W-1:0]  value,
    input  wire logic                           strobe,
    input  wire logic [itoar_pkg::CHAR_W-1:0]   character,
    input  wire logic                           last,
    input  wire logic [itoar_pkg::COUNT_W-1:0]  char_count,
    input  wire logic                           run_done,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  chars_seen
);

    import itoar_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               is_final;
        logic [COUNT_W-1:0] total;
    } digit_item_t;

    digit_item_t expected_digits[$];
    logic        leftovers_checked;

    initial
    begin
        mismatches        = 0;
        pending           = 0;
        chars_seen        = 0;
        leftovers_checked = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches = mismatches + 1;
    endtask

    // Works out the ASCII digit stream of one value, most significant first.
    function automatic void predict_digits(input logic [1:0] radix_sel,
                                           input logic [VALUE_W-1:0] v);
        logic [CHAR_W-1:0]  digit_text [0:NUM_DIGITS-1];
        logic [VALUE_W-1:0] rem;
        logic [VALUE_W-1:0] base;
        logic [DIGIT_W-1:0] d;
        digit_item_t        item;
        int                 n;
        case (radix_sel)
            OP_DEC:  base = 32'd10;
            OP_OCT:  base = 32'd8;
            default: base = 32'd16;
        endcase
        rem = v;
        n   = 0;
        if (rem == '0)
        begin
            digit_text[0] = CHAR_ZERO;
            n = 1;
        end
        else
        begin
            while (rem != '0)
            begin
                d = DIGIT_W'(rem % base);
                if (d < 4'd10)
                    digit_text[n] = CHAR_ZERO + CHAR_W'(d);
                else if (radix_sel == OP_HEX_LO)
                    digit_text[n] = CHAR_LOWER_A + CHAR_W'(d) - 8'd10;
                else
                    digit_text[n] = CHAR_UPPER_A + CHAR_W'(d) - 8'd10;
                rem = rem / base;
                n++;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            item.ch       = digit_text[n - 1 - k];
            item.is_final = (k == n - 1);
            item.total    = item.is_final ? COUNT_W'(n) : '0;
            expected_digits.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        digit_item_t want;
        if (rst_n)
        begin
            // Results go first, so each character is checked before a new transfer's
            // digits are queued, and the queue keeps them in order either way.
            if (strobe)
            begin
                chars_seen = chars_seen + 1;
                if (expected_digits.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 0x%02h last=%0b count=%0d",
                                              character, last, char_count));
                end
                else
                begin
                    want = expected_digits.pop_front();
                    if (character !== want.ch)
                        report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                                  character, want.ch));
                    if (last !== want.is_final)
                        report_mismatch($sformatf("last %0b, wanted %0b",
                                                  last, want.is_final));
                    if (char_count !== want.total)
                        report_mismatch($sformatf("char_count %0d, wanted %0d",
                                                  char_count, want.total));
                end
            end
            if (start && !busy)
                predict_digits(op, value);
            if (run_done && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (expected_digits.size() != 0)
                    report_mismatch($sformatf("%0d characters never arrived",
                                              expected_digits.size()));
            end
        end
        pending <= expected_digits.size();
    end

endmodule

### verif/tb_integer_to_ascii_radix.sv
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix;

    import itoar_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 60;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         op;
    logic [VALUE_W-1:0] value;
    logic               strobe;
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [COUNT_W-1:0] char_count;
    logic               run_done;

    int mismatches;
    int pending;
    int chars_seen;
    int stall_cycles;
    int values_per_radix [0:3];

    integer_to_ascii_radix uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .value      (value),
        .strobe     (strobe),
        .character  (character),
        .last       (last),
        .char_count (char_count)
    );

    itoar_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .value      (value),
        .strobe     (strobe),
        .character  (character),
        .last       (last),
        .char_count (char_count),
        .run_done   (run_done),
        .mismatches (mismatches),
        .pending    (pending),
        .chars_seen (chars_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: nothing transferred for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Holds start high until the converter takes the value, after an optional
    // random idle stretch with start low.
    task automatic convert_value(input logic [1:0] radix_sel,
                                 input logic [VALUE_W-1:0] v,
                                 input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op    <= radix_sel;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        values_per_radix[radix_sel]++;
    endtask

    task automatic wait_for_digits();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic convert_random_values(input int count, input int idle_pct);
        logic [VALUE_W-1:0] raw;
        int                 sig_bits;
        for (int i = 0; i < count; i++)
        begin
            // Spread the magnitude so that every digit count shows up.
            sig_bits = $urandom_range(0, 32);
            raw      = $urandom;
            if (sig_bits < 32)
                raw = raw & ((32'd1 << sig_bits) - 32'd1);
            convert_value(2'($urandom_range(0, 3)), raw, idle_pct);
        end
    endtask

    initial
    begin
        for (int r = 0; r < 4; r++)
            values_per_radix[r] = 0;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        op       <= OP_DEC;
        value    <= '0;
        run_done <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero and all ones in every radix, then digit-count boundaries.
        convert_value(OP_DEC,    32'd0,          12);
        convert_value(OP_OCT,    32'd0,          12);
        convert_value(OP_HEX_UP, 32'd0,          12);
        convert_value(OP_HEX_LO, 32'd0,          12);
        convert_value(OP_DEC,    32'hFFFF_FFFF,  12);
        convert_value(OP_OCT,    32'hFFFF_FFFF,  12);
        convert_value(OP_HEX_UP, 32'hFFFF_FFFF,  12);
        convert_value(OP_HEX_LO, 32'hFFFF_FFFF,  12);
        convert_value(OP_DEC,    32'd1,          12);
        convert_value(OP_DEC,    32'd9,          12);
        convert_value(OP_DEC,    32'd10,         12);
        convert_value(OP_DEC,    32'd999999999,  12);
        convert_value(OP_DEC,    32'd1000000000, 12);
        convert_value(OP_DEC,    32'h8000_0000,  12);
        convert_value(OP_OCT,    32'd7,          12);
        convert_value(OP_OCT,    32'd8,          12);
        convert_value(OP_OCT,    32'h3FFF_FFFF,  12);
        convert_value(OP_OCT,    32'h4000_0000,  12);
        convert_value(OP_HEX_UP, 32'd15,         12);
        convert_value(OP_HEX_LO, 32'd16,         12);
        convert_value(OP_HEX_UP, 32'hFEDC_BA98,  12);
        convert_value(OP_HEX_LO, 32'hFEDC_BA98,  12);
        convert_value(OP_HEX_UP, 32'h0123_4567,  12);
        convert_value(OP_HEX_LO, 32'hABCD_EF01,  12);

        // The sender holds off here until every character has come out.
        wait_for_digits();
        convert_random_values(160, 12);
        wait_for_digits();
        convert_random_values(160, 88);
        wait_for_digits();
        convert_random_values(150, 0);
        wait_for_digits();

        repeat (SETTLE_TICKS) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("converted %0d decimal, %0d octal, %0d upper hex, %0d lower hex values",
                 values_per_radix[OP_DEC], values_per_radix[OP_OCT],
                 values_per_radix[OP_HEX_UP], values_per_radix[OP_HEX_LO]);
        $display("checked %0d characters, %0d mismatches", chars_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
